// ===== rtl/core/source_code_tokenizer_core_macros.svh =====
// Assertion macros for the tokenizer core checker.
`ifndef SOURCE_CODE_TOKENIZER_CORE_MACROS_SVH
`define SOURCE_CODE_TOKENIZER_CORE_MACROS_SVH
// Implication checked on every clock outside reset.
`define SCT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== rtl/core/sctok_pkg.sv =====
// Shared types and constants of the source code tokenizer.
package sctok_pkg;
   localparam int OFFSET_BITS = 24;
   localparam int LINE_BITS = 20;
   localparam int COLUMN_BITS = 16;
   localparam int LEN_BITS = 16;
   localparam int KW_MAX = 6;
   localparam int KW_IDX_BITS = 3;

   typedef enum logic [2:0] {
      ST_IDLE, ST_IDENT, ST_NUMBER, ST_OPPEND, ST_SLASH, ST_COMMENT
   } scan_state_type;

   localparam logic [5:0] K_END = 6'd0;
   localparam logic [5:0] K_ERROR = 6'd1;
   localparam logic [5:0] K_IDENT = 6'd2;
   localparam logic [5:0] K_NUMBER = 6'd3;
   localparam logic [5:0] K_KW_BASE = 6'd4;
   localparam logic [5:0] K_PLUS = 6'd13;
   localparam logic [5:0] K_MINUS = 6'd14;
   localparam logic [5:0] K_STAR = 6'd15;
   localparam logic [5:0] K_SLASH = 6'd16;
   localparam logic [5:0] K_PERCENT = 6'd17;
   localparam logic [5:0] K_LPAREN = 6'd18;
   localparam logic [5:0] K_RPAREN = 6'd19;
   localparam logic [5:0] K_LBRACE = 6'd20;
   localparam logic [5:0] K_RBRACE = 6'd21;
   localparam logic [5:0] K_SEMI = 6'd22;
   localparam logic [5:0] K_ASSIGN = 6'd23;
   localparam logic [5:0] K_LT = 6'd25;
   localparam logic [5:0] K_GT = 6'd27;
   localparam logic [5:0] K_NOT = 6'd29;
   localparam logic [5:0] K_AND = 6'd31;
   localparam logic [5:0] K_OR = 6'd33;

   typedef struct packed {
      logic [5:0] token_kind;
      logic [OFFSET_BITS-1:0] start_offset;
      logic [LINE_BITS-1:0] start_line;
      logic [COLUMN_BITS-1:0] start_column;
      logic [LEN_BITS-1:0] token_length;
      logic [7:0] bad_char;
      logic last;
   } token_type;

   typedef logic [KW_MAX-1:0][7:0] kw_window_type;

   // Keyword table: text padded with zeros, length.
   localparam int KW_COUNT = 9;
   localparam kw_window_type KW_TEXT [KW_COUNT] = '{
      {8'h00, 8'h00, 8'h00, "t", "n", "i"},
      {8'h00, "t", "a", "o", "l", "f"},
      {8'h00, 8'h00, "l", "o", "o", "b"},
      {"e", "l", "b", "u", "o", "d"},
      {8'h00, 8'h00, 8'h00, 8'h00, "f", "i"},
      {8'h00, 8'h00, "e", "s", "l", "e"},
      {8'h00, 8'h00, 8'h00, "r", "o", "f"},
      {8'h00, "e", "l", "i", "h", "w"},
      {"n", "r", "u", "t", "e", "r"}
   };
   localparam logic [KW_IDX_BITS-1:0] KW_LEN [KW_COUNT] = '{
      3'd3, 3'd5, 3'd4, 3'd6, 3'd2, 3'd4, 3'd3, 3'd5, 3'd6
   };

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction
endpackage

// ===== rtl/core/sctok_keyword.sv =====
// Keyword matcher: compares the name window against the keyword table.
module sctok_keyword (
   input  sctok_pkg::kw_window_type window,
   input  logic [sctok_pkg::LEN_BITS-1:0] length,
   output logic [5:0] kind
);
   always_comb begin
      kind = sctok_pkg::K_IDENT;
      for (int i = sctok_pkg::KW_COUNT - 1; i >= 0; i--) begin
         if (length == sctok_pkg::LEN_BITS'(sctok_pkg::KW_LEN[i]) &&
             window == sctok_pkg::KW_TEXT[i])
            kind = sctok_pkg::K_KW_BASE + 6'(i);
      end
   end
endmodule

// ===== rtl/core/sctok_scanner.sv =====
// Scanner state and per-byte token decision, up to two tokens per byte.
module sctok_scanner (
   input  logic clock,
   input  logic reset,
   input  logic step,
   input  logic mode,
   input  logic [7:0] char_code,
   output logic tok0_valid,
   output sctok_pkg::token_type tok0,
   output logic tok1_valid,
   output sctok_pkg::token_type tok1
);
   localparam logic [sctok_pkg::OFFSET_BITS-1:0] OMAX = '1;
   localparam logic [sctok_pkg::LINE_BITS-1:0] LMAX = '1;
   localparam logic [sctok_pkg::COLUMN_BITS-1:0] CMAX = '1;
   localparam logic [sctok_pkg::LEN_BITS-1:0] LENMAX = '1;
   localparam logic [sctok_pkg::LEN_BITS-1:0] LEN_ONE = sctok_pkg::LEN_BITS'(1);
   localparam logic [sctok_pkg::COLUMN_BITS-1:0] COL_ONE = sctok_pkg::COLUMN_BITS'(1);

   sctok_pkg::scan_state_type state_ff, state_in;
   logic [7:0] pend_ff, pend_in;
   sctok_pkg::kw_window_type win_ff, win_in;
   logic [sctok_pkg::OFFSET_BITS-1:0] soff_ff, soff_in, coff_ff, coff_in;
   logic [sctok_pkg::LINE_BITS-1:0] sline_ff, sline_in, cline_ff, cline_in;
   logic [sctok_pkg::COLUMN_BITS-1:0] scol_ff, scol_in, ccol_ff, ccol_in;
   logic [sctok_pkg::LEN_BITS-1:0] len_ff, len_in;
   logic done_ff, done_in;
   logic [5:0] word_kind;

   sctok_keyword u_kw (.window(win_ff), .length(len_ff), .kind(word_kind));

   function automatic logic [5:0] single_kind(input logic [7:0] c);
      unique case (c)
         "=": return sctok_pkg::K_ASSIGN;
         "<": return sctok_pkg::K_LT;
         ">": return sctok_pkg::K_GT;
         "!": return sctok_pkg::K_NOT;
         "&": return sctok_pkg::K_AND;
         default: return sctok_pkg::K_OR;
      endcase
   endfunction

   function automatic logic [7:0] pair_second(input logic [7:0] c);
      if (c == "&") return "&";
      if (c == "|") return "|";
      return "=";
   endfunction

   function automatic sctok_pkg::token_type mk(
      input logic [5:0] k, input logic [sctok_pkg::OFFSET_BITS-1:0] o,
      input logic [sctok_pkg::LINE_BITS-1:0] l,
      input logic [sctok_pkg::COLUMN_BITS-1:0] cl,
      input logic [sctok_pkg::LEN_BITS-1:0] n, input logic [7:0] b, input logic e);
      sctok_pkg::token_type t;
      t.token_kind = k; t.start_offset = o; t.start_line = l;
      t.start_column = cl; t.token_length = n; t.bad_char = b; t.last = e;
      return t;
   endfunction

   always_comb begin
      logic pend_v;
      sctok_pkg::token_type pend_t;
      logic go_idle;
      logic [5:0] k;
      state_in = state_ff; pend_in = pend_ff; win_in = win_ff;
      soff_in = soff_ff; sline_in = sline_ff; scol_in = scol_ff;
      len_in = len_ff; coff_in = coff_ff; cline_in = cline_ff; ccol_in = ccol_ff;
      done_in = done_ff;
      tok0_valid = 1'b0; tok1_valid = 1'b0;
      tok0 = '0; tok1 = '0;
      go_idle = 1'b0;
      k = sctok_pkg::K_ERROR;
      // token pending in the current state, if flushed
      pend_v = 1'b1;
      pend_t = mk(sctok_pkg::K_IDENT, soff_ff, sline_ff, scol_ff, len_ff, 8'h00, 1'b0);
      unique case (state_ff)
         sctok_pkg::ST_IDENT: pend_t.token_kind = word_kind;
         sctok_pkg::ST_NUMBER: pend_t.token_kind = sctok_pkg::K_NUMBER;
         sctok_pkg::ST_OPPEND: begin
            pend_t.token_kind = single_kind(pend_ff);
            pend_t.token_length = LEN_ONE;
         end
         sctok_pkg::ST_SLASH: begin
            pend_t.token_kind = sctok_pkg::K_SLASH;
            pend_t.token_length = LEN_ONE;
         end
         default: pend_v = 1'b0;
      endcase

      if (step && !done_ff) begin
         // position after this byte
         if (coff_ff != OMAX) coff_in = coff_ff + 1'b1;
         if (char_code == 8'h0A) begin
            if (cline_ff != LMAX) cline_in = cline_ff + 1'b1;
            ccol_in = COL_ONE;
         end else if (ccol_ff != CMAX) ccol_in = ccol_ff + 1'b1;

         if (mode) begin
            coff_in = coff_ff; cline_in = cline_ff; ccol_in = ccol_ff;
            done_in = 1'b1;
            state_in = sctok_pkg::ST_IDLE;
            tok0_valid = pend_v;
            tok0 = pend_t;
            tok1_valid = 1'b1;
            tok1 = mk(sctok_pkg::K_END, coff_ff, cline_ff, ccol_ff, '0, 8'h00, 1'b1);
         end else begin
            unique case (state_ff)
               sctok_pkg::ST_IDENT:
                  if (sctok_pkg::is_alpha(char_code) || sctok_pkg::is_digit(char_code)) begin
                     for (int j = 0; j < sctok_pkg::KW_MAX; j++)
                        if (len_ff == sctok_pkg::LEN_BITS'(j)) win_in[j] = char_code;
                     if (len_ff != LENMAX) len_in = len_ff + 1'b1;
                  end else go_idle = 1'b1;
               sctok_pkg::ST_NUMBER:
                  if (sctok_pkg::is_digit(char_code)) begin
                     if (len_ff != LENMAX) len_in = len_ff + 1'b1;
                  end else go_idle = 1'b1;
               sctok_pkg::ST_OPPEND:
                  if (char_code == pair_second(pend_ff)) begin
                     tok1_valid = 1'b1;
                     tok1 = mk(single_kind(pend_ff) + 6'd1, soff_ff, sline_ff, scol_ff,
                               sctok_pkg::LEN_BITS'(2), 8'h00, 1'b0);
                     state_in = sctok_pkg::ST_IDLE;
                  end else go_idle = 1'b1;
               sctok_pkg::ST_SLASH:
                  if (char_code == "/") state_in = sctok_pkg::ST_COMMENT;
                  else go_idle = 1'b1;
               sctok_pkg::ST_COMMENT:
                  if (char_code == 8'h0A) go_idle = 1'b1;
               default: go_idle = 1'b1;
            endcase
            if (go_idle) begin
               tok0_valid = pend_v;
               tok0 = pend_t;
               state_in = sctok_pkg::ST_IDLE;
               if (!(char_code == " " || char_code == 8'h09 || char_code == 8'h0D ||
                     char_code == 8'h0A)) begin
                  soff_in = coff_ff; sline_in = cline_ff; scol_in = ccol_ff;
                  len_in = LEN_ONE;
                  if (sctok_pkg::is_alpha(char_code)) begin
                     win_in = '0;
                     win_in[0] = char_code;
                     state_in = sctok_pkg::ST_IDENT;
                  end else if (sctok_pkg::is_digit(char_code)) begin
                     state_in = sctok_pkg::ST_NUMBER;
                  end else if (char_code == "/") begin
                     state_in = sctok_pkg::ST_SLASH;
                  end else if (char_code == "=" || char_code == "<" || char_code == ">" ||
                               char_code == "!" || char_code == "&" || char_code == "|") begin
                     pend_in = char_code;
                     state_in = sctok_pkg::ST_OPPEND;
                  end else begin
                     unique case (char_code)
                        "+": k = sctok_pkg::K_PLUS;
                        "-": k = sctok_pkg::K_MINUS;
                        "*": k = sctok_pkg::K_STAR;
                        "%": k = sctok_pkg::K_PERCENT;
                        "(": k = sctok_pkg::K_LPAREN;
                        ")": k = sctok_pkg::K_RPAREN;
                        "{": k = sctok_pkg::K_LBRACE;
                        "}": k = sctok_pkg::K_RBRACE;
                        ";": k = sctok_pkg::K_SEMI;
                        default: k = sctok_pkg::K_ERROR;
                     endcase
                     tok1_valid = 1'b1;
                     tok1 = mk(k, coff_ff, cline_ff, ccol_ff, LEN_ONE,
                               (k == sctok_pkg::K_ERROR) ? char_code : 8'h00, 1'b0);
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sctok_pkg::ST_IDLE;
         pend_ff <= '0;
         win_ff <= '0;
         soff_ff <= '0;
         sline_ff <= sctok_pkg::LINE_BITS'(1);
         scol_ff <= COL_ONE;
         len_ff <= '0;
         coff_ff <= '0;
         cline_ff <= sctok_pkg::LINE_BITS'(1);
         ccol_ff <= COL_ONE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff <= pend_in;
         win_ff <= win_in;
         soff_ff <= soff_in;
         sline_ff <= sline_in;
         scol_ff <= scol_in;
         len_ff <= len_in;
         coff_ff <= coff_in;
         cline_ff <= cline_in;
         ccol_ff <= ccol_in;
         done_ff <= done_in;
      end
   end
endmodule

// ===== rtl/core/sctok_out_queue.sv =====
// Four-entry result queue; takes up to two tokens a cycle, gives one while out_ready is high.
module sctok_out_queue (
   input  logic clock,
   input  logic reset,
   input  logic in0_valid,
   input  sctok_pkg::token_type in0,
   input  logic in1_valid,
   input  sctok_pkg::token_type in1,
   output logic space_two,
   output logic out_valid,
   output sctok_pkg::token_type out_data,
   input  logic out_ready
);
   sctok_pkg::token_type slot_ff [4];
   logic [1:0] rd_ff, wr_ff;
   logic [2:0] cnt_ff;
   logic pop;
   logic [1:0] wr1;
   logic [2:0] push_n;

   assign pop = out_valid && out_ready;
   assign out_valid = cnt_ff != 3'd0;
   assign out_data = slot_ff[rd_ff];
   // accept only with room for two tokens regardless of the pop
   assign space_two = cnt_ff <= 3'd2;
   assign wr1 = in0_valid ? wr_ff + 2'd1 : wr_ff;
   assign push_n = {2'b00, in0_valid} + {2'b00, in1_valid};

   always_ff @(posedge clock) begin
      if (in0_valid) slot_ff[wr_ff] <= in0;
      if (in1_valid) slot_ff[wr1] <= in1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0; wr_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_ff + push_n[1:0];
         if (pop) rd_ff <= rd_ff + 2'd1;
         cnt_ff <= cnt_ff + push_n - {2'b00, pop};
      end
   end
endmodule

// ===== rtl/core/source_code_tokenizer_core.sv =====
// Top level of the streaming source code tokenizer.
// Usage:
//  - req_ channel: one transaction per source byte (req_mode = 0) or the
//    end-of-input mark (req_mode = 1). req_ready is high while the result
//    queue has room for two tokens; while it has, bytes stream at one per cycle.
//  - rsp_ channel: one transaction per token, in source order. The end
//    token has rsp_last set; after it every request is taken and dropped.
//  - Order: a closed token is written to the result queue with the byte
//    that closes it. A byte can yield two tokens (flushed plus new).
//  - Throughput: one byte per cycle while req_ready is high; output is one
//    token per cycle from a four-entry queue while rsp_ready is high.
//  - Stall: when rsp_ready is low the queue fills and req_ready drops once
//    fewer than two entries are free; no token is lost.
//  - Reset: synchronous; scanner returns to idle at line 1, column 1,
//    offset 0 and the queue empties.
module source_code_tokenizer_core (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_mode,
   input  logic [7:0] req_char_code,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [5:0] rsp_token_kind,
   output logic [sctok_pkg::OFFSET_BITS-1:0] rsp_start_offset,
   output logic [sctok_pkg::LINE_BITS-1:0] rsp_start_line,
   output logic [sctok_pkg::COLUMN_BITS-1:0] rsp_start_column,
   output logic [sctok_pkg::LEN_BITS-1:0] rsp_token_length,
   output logic [7:0] rsp_bad_char,
   output logic rsp_last
);
   logic t0v, t1v;
   sctok_pkg::token_type t0, t1, head;

   sctok_scanner u_scan (
      .clock, .reset, .step(req_valid && req_ready), .mode(req_mode),
      .char_code(req_char_code), .tok0_valid(t0v), .tok0(t0),
      .tok1_valid(t1v), .tok1(t1)
   );

   sctok_out_queue u_q (
      .clock, .reset, .in0_valid(t0v), .in0(t0), .in1_valid(t1v), .in1(t1),
      .space_two(req_ready), .out_valid(rsp_valid), .out_data(head),
      .out_ready(rsp_ready)
   );

   assign rsp_token_kind = head.token_kind;
   assign rsp_start_offset = head.start_offset;
   assign rsp_start_line = head.start_line;
   assign rsp_start_column = head.start_column;
   assign rsp_token_length = head.token_length;
   assign rsp_bad_char = head.bad_char;
   assign rsp_last = head.last;
endmodule

// ===== rtl/core/sctok_checker.sv =====
// Port-level checker for the tokenizer core and its bind.
`include "source_code_tokenizer_core_macros.svh"
module sctok_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [5:0] rsp_token_kind,
   input logic [15:0] rsp_token_length,
   input logic rsp_last
);
   `SCT_ASSERT_IMP(a_last_is_end, clock, reset, rsp_valid && rsp_last,
      rsp_token_kind == sctok_pkg::K_END && rsp_token_length == 16'd0)
   `SCT_ASSERT_IMP(a_error_len, clock, reset, rsp_valid && rsp_token_kind == sctok_pkg::K_ERROR,
      rsp_token_length == 16'd1)
   `SCT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_token_kind))
endmodule

bind source_code_tokenizer_core sctok_checker u_sctok_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_token_kind, .rsp_token_length, .rsp_last
);

// ===== bench/source_code_tokenizer_checker.sv =====
// Token predictor and result comparator for the source code tokenizer.
module source_code_tokenizer_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  logic req_mode,
   input  logic [7:0] req_char_code,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  logic [5:0] rsp_token_kind,
   input  logic [sctok_pkg::OFFSET_BITS-1:0] rsp_start_offset,
   input  logic [sctok_pkg::LINE_BITS-1:0] rsp_start_line,
   input  logic [sctok_pkg::COLUMN_BITS-1:0] rsp_start_column,
   input  logic [sctok_pkg::LEN_BITS-1:0] rsp_token_length,
   input  logic [7:0] rsp_bad_char,
   input  logic rsp_last,
   output int fail_count,
   output int tokens_pending,
   output int tokens_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [sctok_pkg::OFFSET_BITS-1:0] OFS_MAX = '1;
   localparam logic [sctok_pkg::LINE_BITS-1:0] LN_MAX = '1;
   localparam logic [sctok_pkg::COLUMN_BITS-1:0] COL_MAX = '1;
   localparam logic [sctok_pkg::LEN_BITS-1:0] LEN_MAX = '1;

   sctok_pkg::token_type expected_tokens[$];

   sctok_pkg::scan_state_type lex_state;
   logic [7:0] op_char;
   logic [7:0] word_buf [sctok_pkg::KW_MAX];
   logic [sctok_pkg::OFFSET_BITS-1:0] tok_ofs, cur_ofs;
   logic [sctok_pkg::LINE_BITS-1:0] tok_line, cur_line;
   logic [sctok_pkg::COLUMN_BITS-1:0] tok_col, cur_col;
   logic [sctok_pkg::LEN_BITS-1:0] tok_len;
   logic done;

   function automatic logic letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic [5:0] op_single(input logic [7:0] c);
      case (c)
         "=": return sctok_pkg::K_ASSIGN;
         "<": return sctok_pkg::K_LT;
         ">": return sctok_pkg::K_GT;
         "!": return sctok_pkg::K_NOT;
         "&": return sctok_pkg::K_AND;
         default: return sctok_pkg::K_OR;
      endcase
   endfunction

   function automatic logic [7:0] op_partner(input logic [7:0] c);
      return (c == "&" || c == "|") ? c : 8'("=");
   endfunction

   function automatic logic [5:0] classify_word();
      string names [9];
      bit hit;
      names = '{"int", "float", "bool", "double", "if", "else", "for", "while",
                "return"};
      if (tok_len > sctok_pkg::KW_MAX) return sctok_pkg::K_IDENT;
      for (int i = 0; i < 9; i++) begin
         if (names[i].len() != tok_len) continue;
         hit = 1;
         for (int j = 0; j < names[i].len(); j++)
            if (names[i][j] != word_buf[j]) hit = 0;
         if (hit) return sctok_pkg::K_KW_BASE + 6'(i);
      end
      return sctok_pkg::K_IDENT;
   endfunction

   task automatic push_token(input logic [5:0] kind,
                             input logic [sctok_pkg::OFFSET_BITS-1:0] o,
                             input logic [sctok_pkg::LINE_BITS-1:0] l,
                             input logic [sctok_pkg::COLUMN_BITS-1:0] c,
                             input logic [sctok_pkg::LEN_BITS-1:0] n, input logic [7:0] bad,
                             input logic lst);
      sctok_pkg::token_type t;
      t = '{kind, o, l, c, n, bad, lst};
      expected_tokens.insert(expected_tokens.size(), t);
   endtask

   task automatic step_position(input logic [7:0] c);
      if (cur_ofs != OFS_MAX) cur_ofs++;
      if (c == 8'h0A) begin
         if (cur_line != LN_MAX) cur_line++;
         cur_col = 1;
      end else if (cur_col != COL_MAX) begin
         cur_col++;
      end
   endtask

   task automatic flush_token();
      case (lex_state)
         sctok_pkg::ST_IDENT:
            push_token(classify_word(), tok_ofs, tok_line, tok_col, tok_len, 0, 0);
         sctok_pkg::ST_NUMBER:
            push_token(sctok_pkg::K_NUMBER, tok_ofs, tok_line, tok_col, tok_len, 0, 0);
         sctok_pkg::ST_OPPEND:
            push_token(op_single(op_char), tok_ofs, tok_line, tok_col, 1, 0, 0);
         sctok_pkg::ST_SLASH:
            push_token(sctok_pkg::K_SLASH, tok_ofs, tok_line, tok_col, 1, 0, 0);
         default: ;
      endcase
      lex_state = sctok_pkg::ST_IDLE;
   endtask

   task automatic lex_byte(input logic [7:0] c);
      logic [5:0] kind;
      case (lex_state)
         sctok_pkg::ST_IDENT:
            if (letter(c) || digit(c)) begin
               if (tok_len < sctok_pkg::KW_MAX) word_buf[tok_len] = c;
               if (tok_len != LEN_MAX) tok_len++;
               step_position(c);
               return;
            end else flush_token();
         sctok_pkg::ST_NUMBER:
            if (digit(c)) begin
               if (tok_len != LEN_MAX) tok_len++;
               step_position(c);
               return;
            end else flush_token();
         sctok_pkg::ST_OPPEND:
            if (c == op_partner(op_char)) begin
               push_token(op_single(op_char) + 6'd1, tok_ofs, tok_line, tok_col, 2, 0, 0);
               lex_state = sctok_pkg::ST_IDLE;
               step_position(c);
               return;
            end else flush_token();
         sctok_pkg::ST_SLASH:
            if (c == "/") begin
               lex_state = sctok_pkg::ST_COMMENT;
               step_position(c);
               return;
            end else flush_token();
         sctok_pkg::ST_COMMENT:
            if (c != 8'h0A) begin
               step_position(c);
               return;
            end else lex_state = sctok_pkg::ST_IDLE;
         default: lex_state = sctok_pkg::ST_IDLE;
      endcase
      if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A) begin
         step_position(c);
         return;
      end
      tok_ofs = cur_ofs;
      tok_line = cur_line;
      tok_col = cur_col;
      tok_len = 1;
      if (letter(c)) begin
         foreach (word_buf[i]) word_buf[i] = 0;
         word_buf[0] = c;
         lex_state = sctok_pkg::ST_IDENT;
      end else if (digit(c)) begin
         lex_state = sctok_pkg::ST_NUMBER;
      end else if (c == "/") begin
         lex_state = sctok_pkg::ST_SLASH;
      end else if (c == "=" || c == "<" || c == ">" || c == "!" || c == "&" || c == "|") begin
         op_char = c;
         lex_state = sctok_pkg::ST_OPPEND;
      end else begin
         case (c)
            "+": kind = sctok_pkg::K_PLUS;
            "-": kind = sctok_pkg::K_MINUS;
            "*": kind = sctok_pkg::K_STAR;
            "%": kind = sctok_pkg::K_PERCENT;
            "(": kind = sctok_pkg::K_LPAREN;
            ")": kind = sctok_pkg::K_RPAREN;
            "{": kind = sctok_pkg::K_LBRACE;
            "}": kind = sctok_pkg::K_RBRACE;
            ";": kind = sctok_pkg::K_SEMI;
            default: kind = sctok_pkg::K_ERROR;
         endcase
         push_token(kind, cur_ofs, cur_line, cur_col, 1,
                    kind == sctok_pkg::K_ERROR ? c : 8'h00, 0);
      end
      step_position(c);
   endtask

   always @(posedge clock) begin
      sctok_pkg::token_type seen, want;
      if (reset) begin
         expected_tokens.delete();
         lex_state = sctok_pkg::ST_IDLE;
         op_char = 0;
         foreach (word_buf[i]) word_buf[i] = 0;
         tok_ofs = 0; tok_line = 1; tok_col = 1; tok_len = 0;
         cur_ofs = 0; cur_line = 1; cur_col = 1;
         done = 0;
         fail_count = 0;
         tokens_seen = 0;
      end else begin
         // outputs reflect the previous edge's state; compare first
         if (rsp_valid && rsp_ready) begin
            seen = '{rsp_token_kind, rsp_start_offset, rsp_start_line, rsp_start_column,
                     rsp_token_length, rsp_bad_char, rsp_last};
            tokens_seen++;
            if (expected_tokens.size() == 0) begin
               $display("%0t: unexpected token, expected none, got %p", $time, seen);
               fail_count++;
            end else begin
               want = expected_tokens.pop_front();
               if (seen != want) begin
                  $display("%0t: token mismatch, expected %p, got %p", $time, want, seen);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready && !done) begin
            if (req_mode) begin
               flush_token();
               push_token(sctok_pkg::K_END, cur_ofs, cur_line, cur_col, 0, 0, 1);
               done = 1;
            end else begin
               lex_byte(req_char_code);
            end
         end
      end
      tokens_pending = expected_tokens.size();
   end
endmodule

// ===== bench/tb_source_code_tokenizer_core.sv =====
// Stimulus and verdict for the source code tokenizer core.
module tb_source_code_tokenizer_core;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock, reset;
   logic req_valid, req_ready, req_mode;
   logic [7:0] req_char_code;
   logic rsp_valid, rsp_ready;
   logic [5:0] rsp_token_kind;
   logic [sctok_pkg::OFFSET_BITS-1:0] rsp_start_offset;
   logic [sctok_pkg::LINE_BITS-1:0] rsp_start_line;
   logic [sctok_pkg::COLUMN_BITS-1:0] rsp_start_column;
   logic [sctok_pkg::LEN_BITS-1:0] rsp_token_length;
   logic [7:0] rsp_bad_char;
   logic rsp_last;
   int fail_count, tokens_pending, tokens_seen;
   int bytes_sent;
   // receiver control: long hold-off requested by the sender process
   bit hold_req;
   bit hold_rsp;
   bit stall_on;

   source_code_tokenizer_core uut (.*);
   source_code_tokenizer_checker chk (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("TEST FAILED");
      $finish;
   end

   // Long receiver hold-off, counted here once the sender asks for it.
   initial begin : long_hold
      hold_rsp = 0;
      wait (hold_req);
      hold_rsp = 1;
      repeat (300) @(negedge clock);
      hold_rsp = 0;
   end

   // Receiver: random stall pattern, occasional quiet stretches, and a long hold-off.
   initial begin
      int mode_left;
      rsp_ready = 0;
      mode_left = 0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            stall_on = $urandom_range(0, 2) != 0;
            mode_left = $urandom_range(20, 150);
         end
         mode_left--;
         if (hold_rsp) rsp_ready <= 0;
         else if (stall_on) rsp_ready <= $urandom_range(0, 3) != 0;
         else rsp_ready <= 1;
      end
   end

   // One transaction; valid stays up until the caller idles the channel.
   task automatic send_item(input logic m, input logic [7:0] c);
      req_valid <= 1;
      req_mode <= m;
      req_char_code <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      if (!m) bytes_sent++;
   endtask

   int burst_left;

   task automatic send_paced(input logic m, input logic [7:0] c);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         if ($urandom_range(0, 1)) begin
            req_valid <= 0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
      burst_left--;
      send_item(m, c);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_paced(0, s[i]);
   endtask

   function automatic string random_lexeme();
      string parts [22];
      string w;
      parts = '{"int", "float", "bool", "double", "if", "else", "for", "while",
                "return", "==", "<=", ">=", "!=", "&&", "||", "// note\n", "/",
                "x_9", "returns", "a1234567", "042", ";"};
      case ($urandom_range(0, 5))
         0: return " ";
         1: return "\n";
         default: begin
            w = parts[$urandom_range(0, 21)];
            return w;
         end
      endcase
   endfunction

   task automatic wait_drained();
      req_valid <= 0;
      @(negedge clock);
      while (tokens_pending != 0) @(negedge clock);
   endtask

   initial begin
      string all_ops;
      reset = 1;
      req_valid = 0;
      req_mode = 0;
      req_char_code = 0;
      hold_req = 0;
      bytes_sent = 0;
      burst_left = 0;
      all_ops = "+-*%(){};=<>!&|";
      repeat (10) @(negedge clock);
      reset = 0;

      // Directed: keywords, every operator, comments, odd bytes.
      send_text("int float bool double if else for while return\n");
      send_text("abc_Z9 0123456789 ");
      send_text("== <= >= != && || = < > ! & | ");
      for (int i = 0; i < all_ops.len(); i++) send_paced(0, all_ops[i]);
      send_text("returns x//c\n/ y\t\r");
      send_paced(0, 8'h00);
      send_paced(0, 8'hFF);
      send_paced(0, 8'h80);
      send_paced(0, "@");

      // Receiver holds off while the sender keeps offering bytes.
      hold_req = 1;
      repeat (60) send_text(random_lexeme());
      wait_drained();

      // Random token mix up to the byte budget.
      while (bytes_sent < 630) send_text(random_lexeme());

      // Lone slash closed by end of input, then dropped items.
      send_text(" /");
      send_item(1, 8'h5A);
      send_item(1, 8'h00);
      send_item(0, "x");
      wait_drained();
      repeat (20) @(negedge clock);

      $display("Sent %0d source bytes and checked %0d tokens with bursty input,",
               bytes_sent, tokens_seen);
      $display("random receiver stalls, a long hold-off and a full drain mid-run.");
      if (fail_count == 0 && tokens_pending == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule
